// ----- rtl/mais_pkg.sv -----
// ----------------------------------------------------------------------------
// mais_pkg
// Shared types, codes and saturating helpers for the matrix inverse solver.
// ----------------------------------------------------------------------------
package mais_pkg;

  localparam int MAX_DIM_DEF   = 4;
  localparam int FRAC_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd1;

  // input opcodes
  localparam logic [1:0] OP_WR_MAT  = 2'd0;
  localparam logic [1:0] OP_WR_RHS  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // output modes
  localparam logic [1:0] MODE_SOLVE   = 2'd0;
  localparam logic [1:0] MODE_INVERSE = 2'd1;
  localparam logic [1:0] MODE_DET     = 2'd2;

  // arithmetic unit operations
  localparam logic ARITH_MUL = 1'b0;
  localparam logic ARITH_DIV = 1'b1;

  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic        start;
    logic        op;
    logic [63:0] a;
    logic [63:0] b;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
    logic        sat;
  } arith_rsp_t;

  typedef struct packed {
    logic [63:0] value;
    logic        sat;
  } sat64_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } sat32_t;

  function automatic sat64_t sat_add(input logic [63:0] a, input logic [63:0] b);
    sat64_t     r;
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      r.value = a[63] ? S64_MIN : S64_MAX;
      r.sat   = 1'b1;
    end else begin
      r.value = s;
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  function automatic sat64_t sat_neg(input logic [63:0] a);
    sat64_t r;
    if (a == S64_MIN) begin
      r.value = S64_MAX;
      r.sat   = 1'b1;
    end else begin
      r.value = 64'd0 - a;
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  function automatic sat32_t sat32(input logic [63:0] v);
    sat32_t r;
    if (v[63:31] == {33{1'b0}} || v[63:31] == {33{1'b1}}) begin
      r.value = v[31:0];
      r.sat   = 1'b0;
    end else begin
      r.value = v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      r.sat   = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/mais_ram.sv -----
// ----------------------------------------------------------------------------
// mais_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mais_ram #(
  parameter int W  = 32,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mais_arith.sv -----
// ----------------------------------------------------------------------------
// mais_arith
// Shared fixed-point unit: Q multiply (two 32x32 partial products) and
// restoring Q divide (one quotient bit per cycle), both saturating to 64 bits.
// ----------------------------------------------------------------------------
module mais_arith #(
  parameter int FRAC_BITS = mais_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mais_pkg::arith_req_t req,
  output mais_pkg::arith_rsp_t rsp
);
  import mais_pkg::*;

  localparam int NW  = 64 + FRAC_BITS;
  localparam int NCW = $clog2(NW + 1);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MLO  = 3'd1;
  localparam logic [2:0] A_MHI  = 3'd2;
  localparam logic [2:0] A_MSUM = 3'd3;
  localparam logic [2:0] A_DIV  = 3'd4;
  localparam logic [2:0] A_PACK = 3'd5;

  logic [2:0]     state;
  logic           neg;
  logic [63:0]    ua;
  logic [63:0]    ub;
  logic [63:0]    plo;
  logic [63:0]    phi;
  logic [NW-1:0]  nq;
  logic [63:0]    rem;
  logic [NCW-1:0] cnt;
  logic [63:0]    lo;
  logic           hi_nz;

  logic [31:0]    mul_a;
  logic [63:0]    prod;
  logic [95:0]    psum;
  logic [64:0]    rem2;
  logic           ge;
  logic [63:0]    lim;
  logic           pk_sat;

  // one multiplier, fed by the low or high half of the magnitude
  assign mul_a = (state == A_MHI) ? ua[63:32] : ua[31:0];
  assign prod  = mul_a * ub[31:0];
  assign psum  = {phi, 32'd0} + {32'd0, plo};

  // restoring divide step
  assign rem2 = {rem, nq[NW-1]};
  assign ge   = rem2 >= {1'b0, ub};

  // saturation check on the packed magnitude
  assign lim    = neg ? S64_MIN : S64_MAX;
  assign pk_sat = hi_nz || (lo > lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            neg <= req.a[63] ^ req.b[63];
            ua  <= req.a[63] ? 64'd0 - req.a : req.a;
            ub  <= req.b[63] ? 64'd0 - req.b : req.b;
            nq  <= {(req.a[63] ? 64'd0 - req.a : req.a), {FRAC_BITS{1'b0}}};
            rem <= 64'd0;
            cnt <= NCW'(NW);
            state <= (req.op == ARITH_DIV) ? A_DIV : A_MLO;
          end
        end
        A_MLO: begin
          plo   <= prod;
          state <= A_MHI;
        end
        A_MHI: begin
          phi   <= prod;
          state <= A_MSUM;
        end
        A_MSUM: begin
          lo    <= psum[63+FRAC_BITS:FRAC_BITS];
          hi_nz <= |psum[95:64+FRAC_BITS];
          state <= A_PACK;
        end
        A_DIV: begin
          if (cnt == '0) begin
            lo    <= nq[63:0];
            hi_nz <= |nq[NW-1:64];
            state <= A_PACK;
          end else begin
            rem <= ge ? 64'(rem2 - {1'b0, ub}) : rem2[63:0];
            nq  <= {nq[NW-2:0], ge};
            cnt <= cnt - NCW'(1);
          end
        end
        A_PACK: begin
          rsp.done  <= 1'b1;
          rsp.sat   <= pk_sat;
          rsp.value <= pk_sat ? (neg ? S64_MIN : S64_MAX) : (neg ? 64'd0 - lo : lo);
          state     <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/matrix_adjugate_inverse_solver_unit.sv -----
// ----------------------------------------------------------------------------
// matrix_adjugate_inverse_solver_unit
// Linear-system solver: Laplace determinant, adjugate, inverse, solution.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken when start is high and busy is low.
//   Opcode write-matrix and write-rhs beats store one entry; busy stays
//   low, so loads stream one per cycle.
//   A compute beat raises busy until its last result is out. Results appear
//   on the out_* ports for one cycle each, marked by result_valid, with
//   last_result on the final one; the receiver cannot stall them.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   the user must write it only while no compute is running (the block has no guard).
//   Sequence: minors are built bottom-up over column masks, one multiply per
//   term through the shared arithmetic unit, for the determinant and then
//   the cofactors; then each inverse entry costs one divide (plus one
//   multiply in solve mode). The iterative divider and the single multiplier
//   set the run time.
//   Reset: size_in_use = 4, output_mode = solve, sequencer idle. Stored
//   entries are undefined until written.
// ----------------------------------------------------------------------------
module matrix_adjugate_inverse_solver_unit #(
  parameter int MAX_DIM   = mais_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mais_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      opcode,
  input  logic [1:0]                      row_index,
  input  logic [1:0]                      col_index,
  input  logic signed [31:0]              entry_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mais_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mais_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            result_valid,
  output logic [1:0]                      out_row,
  output logic [1:0]                      out_col,
  output logic signed [31:0]              out_value,
  output logic                            singular,
  output logic                            overflowed,
  output logic                            last_result
);
  import mais_pkg::*;

  localparam int DPW = MAX_DIM;
  localparam int CW  = $clog2(MAX_DIM + 1);
  localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int MD  = MAX_DIM * MAX_DIM;
  localparam int MAW = (MD > 1) ? $clog2(MD) : 1;
  localparam logic [63:0] FX_ONE = 64'd1 << FRAC_BITS;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_INIT   = 5'd1;
  localparam logic [4:0] ST_MASK   = 5'd2;
  localparam logic [4:0] ST_COL    = 5'd3;
  localparam logic [4:0] ST_FETCH  = 5'd4;
  localparam logic [4:0] ST_MWAIT  = 5'd5;
  localparam logic [4:0] ST_DPWR   = 5'd6;
  localparam logic [4:0] ST_DETRD  = 5'd7;
  localparam logic [4:0] ST_DETCAP = 5'd8;
  localparam logic [4:0] ST_CFRD   = 5'd9;
  localparam logic [4:0] ST_CFWR   = 5'd10;
  localparam logic [4:0] ST_ADJEND = 5'd11;
  localparam logic [4:0] ST_ARD    = 5'd12;
  localparam logic [4:0] ST_DIV    = 5'd13;
  localparam logic [4:0] ST_DWAIT  = 5'd14;
  localparam logic [4:0] ST_RMUL   = 5'd15;
  localparam logic [4:0] ST_RWAIT  = 5'd16;

  // configuration and sequencer registers
  logic [2:0]     size_in_use;
  logic [1:0]     output_mode;
  logic [4:0]     state;
  logic [CW-1:0]  n_cur;
  logic           cof_pass;
  logic [DPW:0]   mask_cnt;
  logic [CW-1:0]  c_cnt;
  logic           par;
  logic [CW-1:0]  i_cnt;
  logic [CW-1:0]  j_cnt;
  logic [63:0]    acc;
  logic [63:0]    det;
  logic [63:0]    inv;
  logic           sat_seen;
  logic           base;
  logic [31:0]    rhs [MAX_DIM];

  // combinational helpers
  logic           accept;
  logic [CW-1:0]  n_eff;
  logic [CW-1:0]  n_m1;
  logic [CW-1:0]  kmax;
  logic [CW-1:0]  popc;
  logic [CW-1:0]  pos;
  logic [CW-1:0]  row_sel;
  logic [DPW:0]   full_ext;
  logic [DPW-1:0] full_mask;
  logic [IW-1:0]  c_ix;
  logic [IW-1:0]  j_ix;
  logic           mode_det;
  logic           i_last;
  logic           j_last;
  sat64_t         term_neg;
  sat64_t         cf_neg;
  sat64_t         sum;
  logic [63:0]    term;
  logic           term_sat;
  logic [63:0]    add_b;

  // memories
  logic           mat_we;
  logic [MAW-1:0] mat_waddr;
  logic [MAW-1:0] mat_raddr;
  logic [31:0]    mat_rd;
  logic           dp_we;
  logic [DPW-1:0] dp_waddr;
  logic [63:0]    dp_wdata;
  logic [DPW-1:0] dp_raddr;
  logic [63:0]    dp_rd;
  logic           adj_we;
  logic [MAW-1:0] adj_waddr;
  logic [63:0]    adj_wdata;
  logic [MAW-1:0] adj_raddr;
  logic [63:0]    adj_rd;

  arith_req_t     areq;
  arith_rsp_t     arsp;

  // emission
  logic           em_valid;
  logic [1:0]     em_row;
  logic [1:0]     em_col;
  logic [63:0]    em_val;
  logic           em_sing;
  logic           em_ovf;
  logic           em_last;
  sat32_t         em_s32;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign n_eff = (size_in_use == 3'd0) ? CW'(1) :
                 (32'(size_in_use) > MAX_DIM) ? CW'(MAX_DIM) : CW'(size_in_use);
  assign n_m1      = n_cur - CW'(1);
  assign kmax      = cof_pass ? n_m1 : n_cur;
  assign popc      = CW'($countones(mask_cnt[DPW-1:0]));
  assign pos       = kmax - popc;
  assign row_sel   = (cof_pass && pos >= i_cnt) ? pos + CW'(1) : pos;
  assign full_ext  = (DPW+1)'((1 << n_cur) - 1);
  assign full_mask = full_ext[DPW-1:0];
  assign c_ix      = c_cnt[IW-1:0];
  assign j_ix      = j_cnt[IW-1:0];
  assign mode_det  = (output_mode >= MODE_DET);
  assign i_last    = (i_cnt == n_m1);
  assign j_last    = (j_cnt == n_m1);

  // term sign, accumulate and cofactor sign
  assign term_neg = sat_neg(arsp.value);
  assign term     = par ? term_neg.value : arsp.value;
  assign term_sat = par & term_neg.sat;
  assign add_b    = (state == ST_MWAIT) ? term : arsp.value;
  assign sum      = sat_add(acc, add_b);
  assign cf_neg   = sat_neg(dp_rd);

  // memory ports
  assign mat_we    = accept && (opcode == OP_WR_MAT) &&
                     (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
  assign mat_waddr = MAW'(row_index * MAX_DIM + col_index);
  assign mat_raddr = MAW'(row_sel * MAX_DIM + c_cnt);
  assign adj_raddr = MAW'(i_cnt * MAX_DIM + j_cnt);
  assign adj_we    = (state == ST_CFWR);
  assign adj_waddr = MAW'(j_cnt * MAX_DIM + i_cnt);
  assign adj_wdata = (i_cnt[0] ^ j_cnt[0]) ? cf_neg.value : dp_rd;

  always_comb begin
    dp_raddr = '0;
    if (state == ST_COL) begin
      dp_raddr = mask_cnt[DPW-1:0] & ~(DPW'(1) << c_ix);
    end else if (state == ST_DETRD) begin
      dp_raddr = full_mask;
    end else if (state == ST_CFRD) begin
      dp_raddr = full_mask & ~(DPW'(1) << j_ix);
    end
  end

  assign dp_we    = (state == ST_INIT) || (state == ST_DPWR);
  assign dp_waddr = (state == ST_INIT) ? '0 : mask_cnt[DPW-1:0];
  assign dp_wdata = (state == ST_INIT) ? FX_ONE : acc;

  mais_ram #(.W(32), .D(MD)) u_mat (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(entry_value),
    .raddr(mat_raddr), .rdata(mat_rd)
  );

  mais_ram #(.W(64), .D(1 << DPW)) u_minor (
    .clk(clk), .we(dp_we), .waddr(dp_waddr), .wdata(dp_wdata),
    .raddr(dp_raddr), .rdata(dp_rd)
  );

  mais_ram #(.W(64), .D(MD)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rd)
  );

  // requests to the shared arithmetic unit
  always_comb begin
    areq.start = 1'b0;
    areq.op    = ARITH_MUL;
    areq.a     = dp_rd;
    areq.b     = {{32{mat_rd[31]}}, mat_rd};
    if (state == ST_FETCH) begin
      areq.start = 1'b1;
    end else if (state == ST_DIV) begin
      areq.start = 1'b1;
      areq.op    = ARITH_DIV;
      areq.a     = adj_rd;
      areq.b     = det;
    end else if (state == ST_RMUL) begin
      areq.start = 1'b1;
      areq.a     = inv;
      areq.b     = {{32{rhs[j_ix][31]}}, rhs[j_ix]};
    end
  end

  mais_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk(clk), .rst(rst), .req(areq), .rsp(arsp)
  );

  // pick the result beat to emit
  always_comb begin
    em_valid = 1'b0;
    em_row   = 2'd0;
    em_col   = 2'd0;
    em_val   = 64'd0;
    em_sing  = 1'b0;
    em_ovf   = 1'b0;
    em_last  = 1'b1;
    if (state == ST_DETCAP && mode_det) begin
      em_valid = 1'b1;
      em_val   = dp_rd;
      em_sing  = (dp_rd == 64'd0);
      em_ovf   = sat_seen;
    end else if (state == ST_ADJEND && det == 64'd0) begin
      em_valid = 1'b1;
      em_sing  = 1'b1;
      em_ovf   = sat_seen;
    end else if (state == ST_DWAIT && arsp.done && output_mode == MODE_INVERSE) begin
      em_valid = 1'b1;
      em_row   = 2'(i_cnt);
      em_col   = 2'(j_cnt);
      em_val   = arsp.value;
      em_ovf   = base | sat_seen | arsp.sat;
      em_last  = i_last && j_last;
    end else if (state == ST_RWAIT && arsp.done && j_last) begin
      em_valid = 1'b1;
      em_row   = 2'(i_cnt);
      em_val   = sum.value;
      em_ovf   = base | sat_seen | arsp.sat | sum.sat;
      em_last  = i_last;
    end
  end

  assign em_s32 = sat32(em_val);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= em_valid;
    end
    out_row     <= em_row;
    out_col     <= em_col;
    out_value   <= em_s32.value;
    singular    <= em_sing;
    overflowed  <= em_ovf | em_s32.sat;
    last_result <= em_last;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= 3'd4;
      output_mode <= MODE_SOLVE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIZE: size_in_use <= cfg_data[2:0];
        REG_MODE: output_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // right-hand vector
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_WR_RHS && 32'(row_index) < MAX_DIM) begin
      rhs[IW'(row_index)] <= entry_value;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      det   <= 64'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && opcode == OP_COMPUTE) begin
            n_cur    <= n_eff;
            cof_pass <= 1'b0;
            mask_cnt <= (DPW+1)'(1);
            sat_seen <= 1'b0;
            i_cnt    <= '0;
            state    <= ST_INIT;
          end
        end
        ST_INIT: state <= ST_MASK;
        ST_MASK: begin
          if (mask_cnt > full_ext) begin
            j_cnt <= '0;
            state <= cof_pass ? ST_CFRD : ST_DETRD;
          end else if (popc > kmax) begin
            mask_cnt <= mask_cnt + (DPW+1)'(1);
          end else begin
            acc   <= 64'd0;
            c_cnt <= '0;
            par   <= 1'b0;
            state <= ST_COL;
          end
        end
        ST_COL: begin
          if (c_cnt == n_cur) begin
            state <= ST_DPWR;
          end else if (!mask_cnt[c_ix]) begin
            c_cnt <= c_cnt + CW'(1);
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: state <= ST_MWAIT;
        ST_MWAIT: begin
          if (arsp.done) begin
            acc      <= sum.value;
            sat_seen <= sat_seen | arsp.sat | term_sat | sum.sat;
            par      <= ~par;
            c_cnt    <= c_cnt + CW'(1);
            state    <= ST_COL;
          end
        end
        ST_DPWR: begin
          mask_cnt <= mask_cnt + (DPW+1)'(1);
          state    <= ST_MASK;
        end
        ST_DETRD: state <= ST_DETCAP;
        ST_DETCAP: begin
          det <= dp_rd;
          if (mode_det) begin
            state <= ST_IDLE;
          end else begin
            cof_pass <= 1'b1;
            i_cnt    <= '0;
            mask_cnt <= (DPW+1)'(1);
            state    <= ST_MASK;
          end
        end
        ST_CFRD: state <= ST_CFWR;
        ST_CFWR: begin
          if (i_cnt[0] ^ j_cnt[0]) begin
            sat_seen <= sat_seen | cf_neg.sat;
          end
          if (!j_last) begin
            j_cnt <= j_cnt + CW'(1);
            state <= ST_CFRD;
          end else if (i_last) begin
            state <= ST_ADJEND;
          end else begin
            i_cnt    <= i_cnt + CW'(1);
            mask_cnt <= (DPW+1)'(1);
            state    <= ST_MASK;
          end
        end
        ST_ADJEND: begin
          base     <= sat_seen;
          i_cnt    <= '0;
          j_cnt    <= '0;
          acc      <= 64'd0;
          sat_seen <= 1'b0;
          state    <= (det == 64'd0) ? ST_IDLE : ST_ARD;
        end
        ST_ARD: state <= ST_DIV;
        ST_DIV: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (arsp.done) begin
            if (output_mode == MODE_INVERSE) begin
              sat_seen <= 1'b0;
              if (j_last) begin
                j_cnt <= '0;
                i_cnt <= i_cnt + CW'(1);
                state <= i_last ? ST_IDLE : ST_ARD;
              end else begin
                j_cnt <= j_cnt + CW'(1);
                state <= ST_ARD;
              end
            end else begin
              inv      <= arsp.value;
              sat_seen <= sat_seen | arsp.sat;
              state    <= ST_RMUL;
            end
          end
        end
        ST_RMUL: state <= ST_RWAIT;
        ST_RWAIT: begin
          if (arsp.done) begin
            if (j_last) begin
              acc      <= 64'd0;
              sat_seen <= 1'b0;
              j_cnt    <= '0;
              i_cnt    <= i_cnt + CW'(1);
              state    <= i_last ? ST_IDLE : ST_ARD;
            end else begin
              acc      <= sum.value;
              sat_seen <= sat_seen | arsp.sat | sum.sat;
              j_cnt    <= j_cnt + CW'(1);
              state    <= ST_ARD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mais_checker.sv -----
// ----------------------------------------------------------------------------
// mais_checker
// Port-level checks on the solver's command and result beats.
// ----------------------------------------------------------------------------
module mais_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode,
  input logic       result_valid,
  input logic       singular,
  input logic       last_result
);
  import mais_pkg::*;

  // a compute beat makes the block busy
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_COMPUTE |=> busy)
    else $error("compute beat did not raise busy");

  // results come only out of a compute run
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result beat outside a compute run");

  // more results follow while the run goes on
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_result |=> busy)
    else $error("run ended before its last result");

  // a singular report closes the run
  a_singular_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && singular |-> last_result)
    else $error("singular result not marked last");

endmodule

bind matrix_adjugate_inverse_solver_unit mais_checker u_mais_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the matrix inverse solver. A queue of load
// and compute commands feeds a clocked driver; a Q16.16 model of the Laplace
// determinant, adjugate, inverse and solution predicts every result beat,
// and a monitor compares each beat field by field. Size and output mode are
// swept between phases, including the clamped and aliased settings.
// ----------------------------------------------------------------------------
module testbench;
  import mais_pkg::*;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [1:0] MODE_ALIAS = 2'd3;
  localparam int         FRAC       = FRAC_BITS_DEF;
  localparam logic [63:0] FX_ONE    = 64'd1 << FRAC;
  localparam int         LIMIT      = 3000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic        sing;
    logic        ovf;
    logic        last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] opcode = OP_WR_MAT;
  logic [1:0] row_index = 2'd0;
  logic [1:0] col_index = 2'd0;
  logic signed [31:0] entry_value = 32'sd0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, result_valid, singular, overflowed, last_result;
  logic [1:0] out_row, out_col;
  logic signed [31:0] out_value;

  matrix_adjugate_inverse_solver_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .row_index(row_index), .col_index(col_index),
    .entry_value(entry_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid), .out_row(out_row), .out_col(out_col),
    .out_value(out_value), .singular(singular), .overflowed(overflowed),
    .last_result(last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // solver model state
  logic [31:0] mat_m [16];
  logic [31:0] rhs_m [4];
  logic [63:0] adj_m [16];
  logic [63:0] det_m;
  logic [2:0]  size_m = 3'd4;
  logic [1:0]  mode_m = MODE_SOLVE;
  bit          sat_seen;

  cmd_t  load_plan [$];
  beat_t due_beats [$];
  int    mismatches = 0;
  int    cycles = 0;
  int    planned = 0;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic [63:0] pack_mag(input bit neg, input logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
    if (m > lim) begin
      sat_seen = 1'b1;
      return neg ? S64_MIN : S64_MAX;
    end
    return neg ? 64'd0 - m[63:0] : m[63:0];
  endfunction

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [31:0] b);
    logic [127:0] p;
    p = {64'd0, mag64(a)} * {64'd0, mag64({{32{b[31]}}, b})};
    return pack_mag(a[63] ^ b[31], p >> FRAC);
  endfunction

  function automatic logic [63:0] fx_div(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, mag64(num)} << FRAC) / {64'd0, mag64(den)};
    return pack_mag(num[63] ^ den[63], q);
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_seen = 1'b1;
      return a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic [63:0] neg_sat(input logic [63:0] a);
    if (a == S64_MIN) begin
      sat_seen = 1'b1;
      return S64_MAX;
    end
    return 64'd0 - a;
  endfunction

  // Laplace expansion along the lowest selected row
  function automatic logic [63:0] minor_det(input logic [3:0] rm, input logic [3:0] cm);
    logic [63:0] acc, term;
    int r0, k;
    if (rm == 4'd0) return FX_ONE;
    r0 = 0;
    for (int c = 3; c >= 0; c--) if (rm[c]) r0 = c;
    acc = 64'd0;
    k = 0;
    for (int c = 0; c < 4; c++) begin
      if (cm[c]) begin
        term = fx_mul(minor_det(rm & ~(4'd1 << r0), cm & ~(4'd1 << c)), mat_m[r0*4+c]);
        if (k[0]) term = neg_sat(term);
        acc = add_sat(acc, term);
        k++;
      end
    end
    return acc;
  endfunction

  function automatic void push_beat(input int r, input int c, input logic [63:0] v,
                                    input bit sing, input bit ovf, input bit last);
    beat_t b;
    b.row  = r[1:0];
    b.col  = c[1:0];
    b.sing = sing;
    b.last = last;
    b.ovf  = ovf;
    if (v[63:31] == {33{1'b0}} || v[63:31] == {33{1'b1}}) begin
      b.value = v[31:0];
    end else begin
      b.value = v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      b.ovf   = 1'b1;
    end
    due_beats.push_back(b);
  endfunction

  // work out the result beats of one compute command
  function automatic void solve_predict();
    int n;
    logic [3:0] full;
    logic [63:0] cf, acc, v;
    bit base;
    n = (size_m == 3'd0) ? 1 : (size_m > 3'd4) ? 4 : int'(size_m);
    full = 4'((1 << n) - 1);
    sat_seen = 1'b0;
    det_m = minor_det(full, full);
    if (mode_m >= MODE_DET) begin
      push_beat(0, 0, det_m, det_m == 64'd0, sat_seen, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        cf = minor_det(full & ~(4'd1 << i), full & ~(4'd1 << j));
        if ((i + j) % 2 == 1) cf = neg_sat(cf);
        adj_m[j*4+i] = cf;
      end
    end
    base = sat_seen;
    if (det_m == 64'd0) begin
      push_beat(0, 0, 64'd0, 1'b1, base, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      acc = 64'd0;
      if (mode_m == MODE_SOLVE) sat_seen = 1'b0;
      for (int j = 0; j < n; j++) begin
        if (mode_m == MODE_INVERSE) begin
          sat_seen = 1'b0;
          v = fx_div(adj_m[i*4+j], det_m);
          push_beat(i, j, v, 1'b0, base | sat_seen, i == n - 1 && j == n - 1);
        end else begin
          acc = add_sat(acc, fx_mul(fx_div(adj_m[i*4+j], det_m), rhs_m[j]));
        end
      end
      if (mode_m == MODE_SOLVE) push_beat(i, 0, acc, 1'b0, base | sat_seen, i == n - 1);
    end
  endfunction

  function automatic bit idle_roll();
    if (cycles % 20000 < 4000) return 1'b0;
    return $urandom_range(0, 99) < 32;
  endfunction

  // driver: hold a beat until taken, then advance from the plan
  always @(posedge clk) begin
    cmd_t nx;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        case (opcode)
          OP_WR_MAT:  mat_m[{row_index, col_index}] = entry_value;
          OP_WR_RHS:  rhs_m[row_index] = entry_value;
          OP_COMPUTE: solve_predict();
          default: ;
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SIZE) size_m = cfg_data;
        else mode_m = cfg_data[1:0];
      end
      if (!start || !busy) begin
        if (load_plan.size() > 0 && !idle_roll()) begin
          nx = load_plan.pop_front();
          start       <= 1'b1;
          opcode      <= nx.op;
          row_index   <= nx.row;
          col_index   <= nx.col;
          entry_value <= nx.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    beat_t e;
    if (!rst && result_valid) begin
      if (due_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: row %0d col %0d value %h", out_row, out_col, out_value);
      end else begin
        e = due_beats.pop_front();
        if (e.row !== out_row || e.col !== out_col || e.value !== out_value ||
            e.sing !== singular || e.ovf !== overflowed || e.last !== last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp r%0d c%0d v%h s%0b o%0b l%0b got r%0d c%0d v%h s%0b o%0b l%0b",
                     e.row, e.col, e.value, e.sing, e.ovf, e.last, out_row, out_col,
                     out_value, singular, overflowed, last_result);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("matrix_adjugate_inverse_solver_unit regression: fail");
      $finish;
    end
  end

  task automatic plan(input logic [1:0] op, input int r, input int c, input logic [31:0] v);
    cmd_t k;
    k.op = op;
    k.row = r[1:0];
    k.col = c[1:0];
    k.value = v;
    load_plan.push_back(k);
    planned++;
  endtask

  function automatic logic [31:0] pick_value(input int kind);
    case (kind)
      0: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      1: return 32'($signed($urandom_range(0, 6)) - 3) << FRAC;
      2: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // wait for every beat to land and the sequencer to settle; sample at the
  // falling edge so the driver's and the block's updates have all landed
  task automatic drain();
    do @(negedge clk);
    while (load_plan.size() > 0 || start || due_beats.size() > 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one well-formed problem: load every entry in use, then compute
  task automatic plan_problem(input int n);
    int kind, zr;
    kind = $urandom_range(0, 9);
    kind = (kind < 5) ? 0 : (kind < 8) ? 1 : (kind < 9) ? 2 : 3;
    zr = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        plan(OP_WR_MAT, r, c, (r == zr) ? 32'd0 : pick_value(kind));
    for (int r = 0; r < n; r++) plan(OP_WR_RHS, r, 0, pick_value($urandom_range(0, 3)));
    if ($urandom_range(0, 9) == 0) begin
      plan(OP_IGNORED, $urandom_range(0, 3), $urandom_range(0, 3), $urandom);
      plan(OP_WR_MAT, $urandom_range(0, 3), $urandom_range(0, 3), $urandom);
    end
    plan(OP_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3), $urandom);
  endtask

  initial begin
    logic [2:0] sz;
    logic [2:0] md;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme entries, a mixed system, an ignored opcode
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        plan(OP_WR_MAT, r, c, (r == c) ? 32'h0002_0000 :
             (r == 0 && c == 3) ? 32'h7FFF_FFFF : (r == 3 && c == 0) ? 32'h8000_0000 :
             32'h0000_8000);
    for (int r = 0; r < 4; r++) plan(OP_WR_RHS, r, 0, (r == 3) ? 32'hFFFF_0000 : FX_ONE[31:0]);
    plan(OP_IGNORED, 3, 3, 32'hFFFF_FFFF);
    plan(OP_COMPUTE, 0, 0, 32'd0);
    drain();

    // phases: sweep size and mode, then random settings
    for (int ph = 0; planned < 500; ph++) begin
      sz = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      md = (ph < 8) ? {1'($urandom_range(0, 1)), 2'(ph % 4)} : 3'($urandom_range(0, 7));
      if (ph == 8) md = {1'b0, MODE_ALIAS};
      write_reg(REG_SIZE, sz);
      write_reg(REG_MODE, md);
      n = (sz == 3'd0) ? 1 : (sz > 3'd4) ? 4 : int'(sz);
      repeat ($urandom_range(2, 4)) plan_problem(n);
      drain();
    end

    if (mismatches == 0) begin
      $display("matrix_adjugate_inverse_solver_unit regression: pass");
    end else begin
      $display("matrix_adjugate_inverse_solver_unit regression: fail");
    end
    $finish;
  end

endmodule
